// ----- hdl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit hole allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int NUM_HOLES_DEF = 16;
    localparam int HC_W          = 5;
    localparam int HOLE_W        = 4;
    localparam int SIZE_W        = 16;

    localparam logic [HC_W-1:0] HOLE_COUNT_RESET = 5'd16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_REQ  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        CMD_LOAD  = 2'd0,
        CMD_SKIP  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_WAIT  = 2'd3
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t          kind;
        logic [HOLE_W-1:0]  hole_index;
        logic [SIZE_W-1:0]  size_kb;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic
    {
        BK_IDLE = 1'b0,
        BK_EVAL = 1'b1
    } back_state_t;

endpackage

// ----- hdl/ffha_ifs.sv -----
// ----------------------------------------------------------------------------
// ffha_ifs
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffha_req_if
    import ffha_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [HOLE_W-1:0] hole_index;
    logic [SIZE_W-1:0] size_kb;

    modport source (output valid, output op, output hole_index, output size_kb,
                    input ready);
    modport sink   (input valid, input op, input hole_index, input size_kb,
                    output ready);
endinterface

interface ffha_rsp_if
    import ffha_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [HOLE_W-1:0] chosen_hole;
    logic [SIZE_W-1:0] remaining_kb;

    modport source (output valid, output granted, output chosen_hole,
                    output remaining_kb, input ready);
    modport sink   (input valid, input granted, input chosen_hole,
                    input remaining_kb, output ready);
endinterface

// ----- hdl/ffha_front.sv -----
// ----------------------------------------------------------------------------
// ffha_front
// Accepts request transactions, holds the hole count and classifies items.
// ----------------------------------------------------------------------------
module ffha_front
    import ffha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int LIM_W     = $clog2(NUM_HOLES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [HC_W-1:0]    cfg_wdata,
    ffha_req_if.sink           req,
    input  q_stat_t            q_stat,
    output logic               push,
    output cmd_t               push_cmd,
    output logic [LIM_W-1:0]   limit
);

    logic [HC_W-1:0] hole_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hole_count_reg <= HOLE_COUNT_RESET;
        else if (cfg_we)
            hole_count_reg <= cfg_wdata;
    end

    // A count above the table size searches the whole table.
    assign limit = (32'(hole_count_reg) > NUM_HOLES) ? LIM_W'(NUM_HOLES)
                                                     : LIM_W'(hole_count_reg);

    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full;

    always_comb
    begin
        push_cmd.hole_index = req.hole_index;
        push_cmd.size_kb    = req.size_kb;
        if (req.op == OP_REQ)
            push_cmd.kind = (limit == '0) ? CMD_WAIT : CMD_ALLOC;
        else
            push_cmd.kind = (32'(req.hole_index) < NUM_HOLES) ? CMD_LOAD : CMD_SKIP;
    end

endmodule

// ----- hdl/ffha_fifo.sv -----
// ----------------------------------------------------------------------------
// ffha_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ffha_fifo
    import ffha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg != Q_CNT_W'(Q_DEPTH))
        else $error("queue written while full");

    no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue read while empty");

endmodule

// ----- hdl/ffha_back.sv -----
// ----------------------------------------------------------------------------
// ffha_back
// Hole table cells, first-fit search and update, and the response register.
// ----------------------------------------------------------------------------
module ffha_back
    import ffha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int LIM_W     = $clog2(NUM_HOLES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               head,
    input  q_stat_t            q_stat,
    input  logic [LIM_W-1:0]   limit,
    output logic               pop,
    ffha_rsp_if.source         rsp
);

    back_state_t            state_reg;
    back_state_t            state_next;
    cmd_t                   cmd_reg;
    logic [NUM_HOLES-1:0]   fit_reg;
    logic [NUM_HOLES-1:0]   fit_next;
    logic [NUM_HOLES-1:0]   lane_en;
    logic [NUM_HOLES-1:0]   pick;
    logic [SIZE_W-1:0]      hole_reg  [NUM_HOLES];
    logic [SIZE_W-1:0]      hole_next [NUM_HOLES];
    logic [SIZE_W-1:0]      diff      [NUM_HOLES];
    logic [SIZE_W-1:0]      remaining;
    logic [HOLE_W-1:0]      chosen;
    logic                   fire;
    logic                   out_free;

    logic                   out_valid_reg;
    logic                   granted_reg;
    logic [HOLE_W-1:0]      chosen_reg;
    logic [SIZE_W-1:0]      remaining_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_EVAL;
            BK_EVAL: if (out_free)      state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        fire = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop  = !q_stat.empty;
            BK_EVAL: fire = out_free;
            default: ;
        endcase
    end

    // Each cell compares its own free size against the queued request.
    always_comb
    begin
        for (int i = 0; i < NUM_HOLES; i++)
        begin
            lane_en[i]  = (32'(limit) > i);
            fit_next[i] = lane_en[i] && (head.kind == CMD_ALLOC) &&
                          (head.size_kb <= hole_reg[i]);
        end
    end

    // The lowest set bit of the fit mask is the first fitting hole.
    assign pick = fit_reg & (~fit_reg + 1'b1);

    always_comb
    begin
        remaining = '0;
        chosen    = '0;
        for (int i = 0; i < NUM_HOLES; i++)
        begin
            diff[i] = hole_reg[i] - cmd_reg.size_kb;
            if (pick[i])
            begin
                remaining = remaining | diff[i];
                chosen    = chosen | HOLE_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_HOLES; i++)
        begin
            hole_next[i] = hole_reg[i];
            if (fire)
            begin
                if (cmd_reg.kind == CMD_LOAD && 32'(cmd_reg.hole_index) == i)
                    hole_next[i] = cmd_reg.size_kb;
                else if (pick[i])
                    hole_next[i] = diff[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_HOLES; i++)
                hole_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_HOLES; i++)
                hole_reg[i] <= hole_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                fit_reg <= fit_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head;
        if (fire)
        begin
            granted_reg   <= |pick;
            chosen_reg    <= chosen;
            remaining_reg <= remaining;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = granted_reg;
    assign rsp.chosen_hole  = chosen_reg;
    assign rsp.remaining_kb = remaining_reg;

    fit_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_EVAL |-> (fit_reg & ~lane_en) == '0)
        else $error("fit mask covers a hole outside the searched range");

    idle_response_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !granted_reg |-> chosen_reg == '0 && remaining_reg == '0)
        else $error("response without a grant carries nonzero fields");

endmodule

// ----- hdl/first_fit_hole_allocator.sv -----
// Each request passes the queue, the fit mask and command registers and the response register.
// The hole cells take a new item only once the last one's result enters the response register.
// Input transactions are taken while the two-entry queue has room, even when a result waits.
// Reset clears every hole to zero and sets the hole count to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// first_fit_hole_allocator
// First-fit allocator over a table of free hole sizes with load and request items.
// ----------------------------------------------------------------------------
module first_fit_hole_allocator
    import ffha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [HC_W-1:0] cfg_wdata,
    ffha_req_if.sink        req,
    ffha_rsp_if.source      rsp
);

    localparam int LIM_W = $clog2(NUM_HOLES + 1);

    logic             push;
    logic             pop;
    cmd_t             push_cmd;
    cmd_t             head;
    q_stat_t          q_stat;
    logic [LIM_W-1:0] limit;

    ffha_front #(
        .NUM_HOLES (NUM_HOLES),
        .LIM_W     (LIM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd),
        .limit     (limit)
    );

    ffha_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ffha_back #(
        .NUM_HOLES (NUM_HOLES),
        .LIM_W     (LIM_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .limit  (limit),
        .pop    (pop),
        .rsp    (rsp)
    );

endmodule
